// ----- rtl/core/crc16cb_pkg.sv -----
// ----------------------------------------------------------------------------
// crc16cb_pkg
// Shared types and constants for the configurable bytewise crc engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16cb_pkg;

    // default crc register width
    localparam int CRC_WIDTH_DEFAULT = 16;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // result field width
    localparam int CRC_OUT_W = 16;

    // input byte width
    localparam int BYTE_W = 8;

    // widest supported crc register, used for zero extension
    localparam int CRC_EXT_W = 32;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] POLY_RESET      = 16'h1021;
    localparam logic [CFG_DATA_W-1:0] SEED_RESET      = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0] FINAL_XOR_RESET = 16'h0000;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POLYNOMIAL     = 3'd0,
        REG_SEED           = 3'd1,
        REG_REFLECT_INPUT  = 3'd2,
        REG_REFLECT_OUTPUT = 3'd3,
        REG_FINAL_XOR      = 3'd4
    } cfg_index_t;

    // item opcodes
    typedef enum logic {
        OP_DATA   = 1'b0,
        OP_RELOAD = 1'b1
    } opcode_t;

endpackage : crc16cb_pkg

`default_nettype wire

// ----- rtl/core/crc16_configurable_bytewise.sv -----
// ----------------------------------------------------------------------------
// crc16_configurable_bytewise
// Bytewise crc engine with programmable polynomial, seed, reflection and
// final xor. Each input transfer folds one byte (or reloads the seed) and
// produces one crc value.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------
//  in        sink       in_valid / in_ready    opcode[0:0], data_byte[7:0]
//  out       source     out_valid / out_ready  crc_value[15:0]
//  cfg       sink       cfg_write (no wait)    cfg_index[2:0], cfg_data[15:0]
//
//  path: an item passes the input register, then the output register that
//    holds crc_value; throughput is one item per cycle while the output side
//    is not stalled (see stalls); the eight shift steps of a byte are unrolled
//    between the input register and the crc/result registers
//  reset: asynchronous, active low; crc register loads the seed reset value,
//    configuration registers load their defaults
//  stalls: in_ready drops only while both the input register and the output
//    register hold items and out_ready is low
//
`default_nettype none

module crc16_configurable_bytewise
    import crc16cb_pkg::*;
#(
    parameter int CRC_WIDTH = CRC_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // configuration write port
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   opcode,
    input  wire logic [BYTE_W-1:0]      data_byte,

    // output channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CRC_OUT_W-1:0]        crc_value
);

    // seed reset value fitted to the register width
    localparam logic [CRC_EXT_W-1:0] SEED_RESET_EXT = CRC_EXT_W'(SEED_RESET);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] poly_reg;
    logic [CFG_DATA_W-1:0] seed_reg;
    logic                  refl_in_reg;
    logic                  refl_out_reg;
    logic [CFG_DATA_W-1:0] final_xor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            seed_reg      <= SEED_RESET;
            refl_in_reg   <= 1'b0;
            refl_out_reg  <= 1'b0;
            final_xor_reg <= FINAL_XOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_POLYNOMIAL:     poly_reg      <= cfg_data;
                REG_SEED:           seed_reg      <= cfg_data;
                REG_REFLECT_INPUT:  refl_in_reg   <= cfg_data[0];
                REG_REFLECT_OUTPUT: refl_out_reg  <= cfg_data[0];
                REG_FINAL_XOR:      final_xor_reg <= cfg_data;
                default:            ; // unknown index, write dropped
            endcase
        end
    end

    // config values zero extended / truncated to the register width
    logic [CRC_EXT_W-1:0] poly_ext;
    logic [CRC_EXT_W-1:0] seed_ext;
    logic [CRC_EXT_W-1:0] xor_ext;
    logic [CRC_WIDTH-1:0] poly_w;
    logic [CRC_WIDTH-1:0] seed_w;
    logic [CRC_WIDTH-1:0] xor_w;

    assign poly_ext = CRC_EXT_W'(poly_reg);
    assign seed_ext = CRC_EXT_W'(seed_reg);
    assign xor_ext  = CRC_EXT_W'(final_xor_reg);
    assign poly_w   = poly_ext[CRC_WIDTH-1:0];
    assign seed_w   = seed_ext[CRC_WIDTH-1:0];
    assign xor_w    = xor_ext[CRC_WIDTH-1:0];

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_valid_next;
    opcode_t           s1_op_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              advance;
    logic              in_xfer;

    // the item in the input register moves on when the output register frees
    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg   <= opcode_t'(opcode);
            s1_byte_reg <= data_byte;
        end
    end

    // ------------------------------------------------------------------
    // byte fold: eight unrolled msb-first shift steps, no augmentation
    // ------------------------------------------------------------------
    logic [CRC_WIDTH-1:0] crc_reg;
    logic [CRC_WIDTH-1:0] crc_next;
    logic [BYTE_W-1:0]    byte_w;
    logic [CRC_WIDTH-1:0] crc_shift;
    logic [CRC_WIDTH-1:0] crc_refl;
    logic                 fb;

    always_comb
    begin
        byte_w    = s1_byte_reg;
        crc_shift = crc_reg;
        crc_refl  = '0;
        fb        = 1'b0;

        // optional input byte reflection
        if (refl_in_reg)
        begin
            for (int i = 0; i < BYTE_W; i++)
            begin
                byte_w[i] = s1_byte_reg[BYTE_W-1-i];
            end
        end

        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb        = crc_shift[CRC_WIDTH-1] ^ byte_w[i];
            crc_shift = {crc_shift[CRC_WIDTH-2:0], 1'b0};
            if (fb)
            begin
                crc_shift = crc_shift ^ poly_w;
            end
        end

        // optional full-width output reflection
        for (int i = 0; i < CRC_WIDTH; i++)
        begin
            crc_refl[i] = crc_shift[CRC_WIDTH-1-i];
        end

        // the reflected, xored value is what the next byte folds into
        if (s1_op_reg == OP_RELOAD)
        begin
            crc_next = seed_w;
        end
        else if (refl_out_reg)
        begin
            crc_next = crc_refl ^ xor_w;
        end
        else
        begin
            crc_next = crc_shift ^ xor_w;
        end
    end

    // ------------------------------------------------------------------
    // crc state and output register
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CRC_OUT_W-1:0] out_crc_reg;
    logic [CRC_EXT_W-1:0] crc_next_ext;

    assign crc_next_ext = CRC_EXT_W'(crc_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= SEED_RESET_EXT[CRC_WIDTH-1:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_crc_reg <= crc_next_ext[CRC_OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_crc_reg;

endmodule : crc16_configurable_bytewise

`default_nettype wire

// ----- rtl/core/crc16cb_checker.sv -----
// ----------------------------------------------------------------------------
// crc16cb_port_checker
// Port-level checks of the crc engine's transfer ordering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cb_port_checker
    import crc16cb_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [CRC_OUT_W-1:0] crc_value
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crc_value))
        else $error("result changed or dropped while stalled");

    // input backpressure only comes from a full, stalled output side
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a new result comes from an input transfer through the input register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input transfer");

    // an input transfer into an empty output side is shown on out_valid
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("result missing after input transfer");

endmodule : crc16cb_port_checker

bind crc16_configurable_bytewise crc16cb_port_checker u_crc16cb_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_value (crc_value)
);

`default_nettype wire

// ----- tb/crc16cb_checker.sv -----
// ----------------------------------------------------------------------------
// crc16cb_checker
// Watches the config port and both channels of the crc engine, keeps its own
// copy of the crc register and settings, and compares every output transfer
// with the oldest predicted crc value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crc16cb_checker
    import crc16cb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   opcode,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [CRC_OUT_W-1:0]   crc_value,
    output int                     fail_count,
    output int                     pending
);

    logic [CRC_OUT_W-1:0] cur_poly    = POLY_RESET;
    logic [CRC_OUT_W-1:0] cur_seed    = SEED_RESET;
    logic                 cur_refin   = 1'b0;
    logic                 cur_refout  = 1'b0;
    logic [CRC_OUT_W-1:0] cur_xorout  = FINAL_XOR_RESET;
    logic [CRC_OUT_W-1:0] crc_model   = SEED_RESET;
    logic [CRC_OUT_W-1:0] expected_crc_q[$];
    logic [CRC_OUT_W-1:0] want;

    initial fail_count = 0;
    initial pending = 0;

    // msb-first shift of one byte, then optional reflect and final xor
    function automatic logic [CRC_OUT_W-1:0] fold_byte(
        input logic [CRC_OUT_W-1:0] crc_in,
        input logic [BYTE_W-1:0]    byte_in
    );
        logic [CRC_OUT_W-1:0] crc;
        logic [CRC_OUT_W-1:0] flipped;
        logic [BYTE_W-1:0]    bits;
        logic                 feedback;
        int                   i;
        crc  = crc_in;
        bits = byte_in;
        if (cur_refin)
            for (i = 0; i < BYTE_W; i++)
                bits[i] = byte_in[BYTE_W-1-i];
        for (i = BYTE_W - 1; i >= 0; i--)
        begin
            feedback = crc[CRC_OUT_W-1] ^ bits[i];
            crc = {crc[CRC_OUT_W-2:0], 1'b0};
            if (feedback)
                crc = crc ^ cur_poly;
        end
        if (cur_refout)
        begin
            for (i = 0; i < CRC_OUT_W; i++)
                flipped[i] = crc[CRC_OUT_W-1-i];
            crc = flipped;
        end
        return crc ^ cur_xorout;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_poly   = POLY_RESET;
            cur_seed   = SEED_RESET;
            cur_refin  = 1'b0;
            cur_refout = 1'b0;
            cur_xorout = FINAL_XOR_RESET;
            crc_model  = SEED_RESET;
            expected_crc_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POLYNOMIAL:     cur_poly   = cfg_data;
                    REG_SEED:           cur_seed   = cfg_data;
                    REG_REFLECT_INPUT:  cur_refin  = cfg_data[0];
                    REG_REFLECT_OUTPUT: cur_refout = cfg_data[0];
                    REG_FINAL_XOR:      cur_xorout = cfg_data;
                    default:            ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_crc_q.size() == 0)
                begin
                    $display("%0t unexpected output transfer: expected none, actual crc_value %04h",
                             $time, crc_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_crc_q.pop_front();
                    if (crc_value !== want)
                    begin
                        $display("%0t crc_value mismatch: expected %04h, actual %04h",
                                 $time, want, crc_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == OP_RELOAD)
                    crc_model = cur_seed;
                else
                    crc_model = fold_byte(crc_model, data_byte);
                expected_crc_q.push_back(crc_model);
            end
            pending <= expected_crc_q.size();
        end
    end

endmodule : crc16cb_checker

// ----- tb/tb_crc16_configurable_bytewise.sv -----
// ----------------------------------------------------------------------------
// tb_crc16_configurable_bytewise
// Directed and random stimulus for the configurable bytewise crc engine:
// known check strings, extreme and random settings, reload commands and
// random idling on both channels. The checker module does all comparisons.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_crc16_configurable_bytewise;
    import crc16cb_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES    = 60;
    // quiet cycles after the last result
    localparam int TAIL_CYCLES    = 8;
    // random transfers per settings phase
    localparam int PHASE_ITEMS    = 72;
    localparam int NUM_PHASES     = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   opcode    = OP_DATA;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [CRC_OUT_W-1:0]   crc_value;

    int  fail_count;
    int  pending;
    int  idle_cycles   = 0;
    // per-cycle idle odds in percent, changed between phases
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    // request for one long receiver hold-off
    bit  hold_req      = 1'b0;

    crc16_configurable_bytewise u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value)
    );

    crc16cb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .crc_value  (crc_value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold off long enough for the engine to fill and drop in_ready
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("[crc16_configurable_bytewise] ERROR");
            $finish;
        end
    end

    // one input transfer, preceded by a random idle gap
    task automatic feed_item(input opcode_t op, input logic [BYTE_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted crc value has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // one config write; cfg_write stays high until the caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // full crc setup; reflect flags are passed wide so upper bits get exercised
    task automatic program_crc(input logic [CFG_DATA_W-1:0] poly,
                               input logic [CFG_DATA_W-1:0] seed,
                               input logic [CFG_DATA_W-1:0] refin,
                               input logic [CFG_DATA_W-1:0] refout,
                               input logic [CFG_DATA_W-1:0] xorout);
        write_reg(REG_POLYNOMIAL, poly);
        write_reg(REG_SEED, seed);
        write_reg(REG_REFLECT_INPUT, refin);
        write_reg(REG_REFLECT_OUTPUT, refout);
        write_reg(REG_FINAL_XOR, xorout);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        string check_str;
        int    i;
        int    p;
        int    mode;
        check_str = "123456789";

        // reset held low from the start, released on a clock edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings (ccitt-false)
        feed_item(OP_RELOAD, 8'h00);
        for (i = 0; i < check_str.len(); i++)
            feed_item(OP_DATA, check_str[i]);
        feed_item(OP_DATA, 8'h00);
        feed_item(OP_DATA, 8'hFF);
        feed_item(OP_DATA, 8'h80);
        feed_item(OP_DATA, 8'h01);
        // reload ignores its data byte
        feed_item(OP_RELOAD, 8'hFF);
        feed_item(OP_DATA, 8'hFF);
        feed_item(OP_RELOAD, 8'hA5);
        wait_drained();

        // writes to unused indexes must be dropped; zero would wreck poly/seed
        for (i = REG_FINAL_XOR + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), 16'h0000);
        // only bit 0 of the reflect flags is kept
        write_reg(REG_REFLECT_INPUT, 16'hFFFF);
        write_reg(REG_REFLECT_OUTPUT, 16'hFFFE);
        cfg_write <= 1'b0;
        feed_item(OP_RELOAD, 8'h00);
        feed_item(OP_DATA, 8'h01);
        feed_item(OP_DATA, 8'h80);
        feed_item(OP_DATA, 8'hFF);
        feed_item(OP_DATA, 8'h5A);
        wait_drained();

        // random part: four idle modes, each with an extreme and a random setup
        for (p = 0; p < NUM_PHASES; p++)
        begin
            mode = p / 2;
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (p % 2 == 0)
            begin
                case (mode)
                    0: program_crc(16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'hFFFF);
                    1: program_crc(16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
                    2: program_crc(16'h8005, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
                    default: program_crc(16'h1021, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
                endcase
            end
            else
                program_crc(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));

            // back-pressure: long hold-off while the sender keeps offering
            if (p == 1)
                hold_req = 1'b1;

            // mostly byte streams, each reload starts a fresh message
            feed_item(OP_RELOAD, 8'($urandom));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 8)
                    feed_item(OP_RELOAD, 8'($urandom));
                else
                    feed_item(OP_DATA, 8'($urandom_range(255)));
            end
            wait_drained();
        end

        // quiet tail so a stray late output would still be caught
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[crc16_configurable_bytewise] OK");
        else
            $display("[crc16_configurable_bytewise] ERROR");
        $finish;
    end

endmodule : tb_crc16_configurable_bytewise
